@@ design/mwc_pkg.sv @@
// Shared types and constants for the multiply-with-carry generator.
// No dependencies; imported by mwc_mac and multiply_with_carry_rng.
package mwc_pkg;

    localparam int WordW = 32;
    localparam int AccW  = 64;

    localparam logic [WordW-1:0] SeedMult = 32'd29943829;
    localparam logic [WordW-1:0] CoefX0   = 32'd5115;
    localparam logic [WordW-1:0] CoefX1   = 32'd1776;
    localparam logic [WordW-1:0] CoefX2   = 32'd1492;
    localparam logic [WordW-1:0] CoefX3   = 32'd2111111111;

    localparam logic [WordW-1:0] ResetX0    = 32'h95d3474b;
    localparam logic [WordW-1:0] ResetX1    = 32'h035cf1f7;
    localparam logic [WordW-1:0] ResetX2    = 32'hfd43995f;
    localparam logic [WordW-1:0] ResetX3    = 32'h5dfc55fb;
    localparam logic [WordW-1:0] ResetCarry = 32'h334a9229;

    // Controls for the shared multiply-accumulate unit
    typedef struct packed {
        logic load_prod;  // register op_a * op_b
        logic acc_init;   // load accumulator with init value
        logic acc_add;    // add held product into accumulator
    } mac_ctrl_t;

    // Coefficient for history word k
    function automatic logic [WordW-1:0] mwc_coef(input logic [1:0] k);
        logic [WordW-1:0] c;
        case (k)
            2'd0:    c = CoefX0;
            2'd1:    c = CoefX1;
            2'd2:    c = CoefX2;
            default: c = CoefX3;
        endcase
        return c;
    endfunction

endpackage

@@ design/multiply_with_carry_rng.sv @@
// Top level of the four-lag multiply-with-carry generator: sequencer and state.
// Depends on mwc_pkg and mwc_mac.
//
// A request with s_tuser low generates one 32-bit word: it is accepted in the
// idle state, runs through the shared multiplier/accumulator (four products
// issued one per cycle, each added in the following cycle, starting from the
// carry), and an update state shifts the history and presents the word on
// m_tdata. Words are made one at a time by the single multiplier. A request with
// s_tuser high reseeds from s_tdata: five seed words, each through a multiply
// state and a write state on the same multiplier, then WARMUP_ROUNDS silent
// rounds with no result. s_tready is high only while the block is idle; a
// finished word sits in the output register while the next request is accepted.
module multiply_with_carry_rng #(
    parameter int WARMUP_ROUNDS = 19
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed_value
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] random_word
);
    import mwc_pkg::*;

    localparam int WarmW = (WARMUP_ROUNDS > 0) ? $clog2(WARMUP_ROUNDS + 1) : 1;

    localparam logic [2:0] StIdle    = 3'd0;
    localparam logic [2:0] StSeedMul = 3'd1;
    localparam logic [2:0] StSeedWr  = 3'd2;
    localparam logic [2:0] StMac     = 3'd3;
    localparam logic [2:0] StUpdate  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       step_reg, step_next;
    logic [WordW-1:0] hist_reg [4];
    logic [WordW-1:0] hist_next [4];
    logic [WordW-1:0] carry_reg, carry_next;
    logic [WordW-1:0] seed_reg, seed_next;
    logic [WarmW-1:0] warm_reg, warm_next;
    logic             emit_reg, emit_next;
    logic             mvalid_reg, mvalid_next;
    logic [WordW-1:0] mdata_reg, mdata_next;

    mac_ctrl_t        mac_ctrl;
    logic [WordW-1:0] op_a, op_b;
    logic [WordW-1:0] seed_word;
    logic [AccW-1:0]  prod, acc;

    mwc_mac u_mac (
        .aclk     (aclk),
        .ctrl     (mac_ctrl),
        .op_a     (op_a),
        .op_b     (op_b),
        .init_val (carry_reg),
        .prod     (prod),
        .acc      (acc)
    );

    assign seed_word = prod[WordW-1:0] - WordW'(1);

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        hist_next   = hist_reg;
        carry_next  = carry_reg;
        seed_next   = seed_reg;
        warm_next   = warm_reg;
        emit_next   = emit_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mac_ctrl    = '0;
        op_a        = hist_reg[step_reg[1:0]];
        op_b        = mwc_coef(step_reg[1:0]);

        // drop the output word once taken
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            StIdle: begin
                if (s_tvalid) begin
                    step_next = '0;
                    if (s_tuser) begin
                        seed_next  = s_tdata;
                        state_next = StSeedMul;
                    end else begin
                        emit_next  = 1'b1;
                        state_next = StMac;
                    end
                end
            end
            StSeedMul: begin
                op_a               = seed_reg;
                op_b               = SeedMult;
                mac_ctrl.load_prod = 1'b1;
                state_next         = StSeedWr;
            end
            StSeedWr: begin
                seed_next = seed_word;
                if (step_reg == 3'd4) begin
                    carry_next = seed_word;
                    warm_next  = WarmW'(WARMUP_ROUNDS);
                    emit_next  = 1'b0;
                    step_next  = '0;
                    state_next = (WARMUP_ROUNDS == 0) ? StIdle : StMac;
                end else begin
                    hist_next[step_reg[1:0]] = seed_word;
                    step_next  = step_reg + 3'd1;
                    state_next = StSeedMul;
                end
            end
            StMac: begin
                // issue one product per step, add it one step later
                mac_ctrl.load_prod = (step_reg != 3'd4);
                mac_ctrl.acc_init  = (step_reg == 3'd0);
                mac_ctrl.acc_add   = (step_reg != 3'd0);
                if (step_reg == 3'd4) begin
                    state_next = StUpdate;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            StUpdate: begin
                // hold while a previous word still waits downstream
                if (!(emit_reg && mvalid_reg && !m_tready)) begin
                    hist_next[3] = hist_reg[2];
                    hist_next[2] = hist_reg[1];
                    hist_next[1] = hist_reg[0];
                    hist_next[0] = acc[WordW-1:0];
                    carry_next   = acc[AccW-1:WordW];
                    step_next    = '0;
                    if (emit_reg) begin
                        mvalid_next = 1'b1;
                        mdata_next  = acc[WordW-1:0];
                        state_next  = StIdle;
                    end else begin
                        warm_next  = warm_reg - WarmW'(1);
                        state_next = (warm_reg == WarmW'(1)) ? StIdle : StMac;
                    end
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase
    end

    // Control state and generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= StIdle;
            step_reg    <= '0;
            warm_reg    <= '0;
            emit_reg    <= 1'b0;
            mvalid_reg  <= 1'b0;
            hist_reg[0] <= ResetX0;
            hist_reg[1] <= ResetX1;
            hist_reg[2] <= ResetX2;
            hist_reg[3] <= ResetX3;
            carry_reg   <= ResetCarry;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            warm_reg   <= warm_next;
            emit_reg   <= emit_next;
            mvalid_reg <= mvalid_next;
            hist_reg   <= hist_next;
            carry_reg  <= carry_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        seed_reg  <= seed_next;
        mdata_reg <= mdata_next;
    end

    assign s_tready = (state_reg == StIdle);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

@@ design/mwc_mac.sv @@
// Shared 32x32 multiplier with a registered product and a 64-bit accumulator.
// Depends on mwc_pkg.
module mwc_mac (
    input  logic                      aclk,
    input  mwc_pkg::mac_ctrl_t        ctrl,
    input  logic [mwc_pkg::WordW-1:0] op_a,
    input  logic [mwc_pkg::WordW-1:0] op_b,
    input  logic [mwc_pkg::WordW-1:0] init_val,
    output logic [mwc_pkg::AccW-1:0]  prod,
    output logic [mwc_pkg::AccW-1:0]  acc
);
    import mwc_pkg::*;

    logic [AccW-1:0] prod_reg, prod_next;
    logic [AccW-1:0] acc_reg, acc_next;

    // Multiply stage, then accumulate from the held product
    always_comb begin
        prod_next = prod_reg;
        acc_next  = acc_reg;
        if (ctrl.load_prod) begin
            prod_next = AccW'(op_a) * AccW'(op_b);
        end
        if (ctrl.acc_init) begin
            acc_next = AccW'(init_val);
        end else if (ctrl.acc_add) begin
            acc_next = acc_reg + prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

@@ sim/tb.sv @@
// Testbench for multiply_with_carry_rng. A scoreboard class predicts each word and
// checks it against m_tdata, with handshake pacing on both sides.
// Depends on design/multiply_with_carry_rng.sv and, through it, design/mwc_pkg.sv and design/mwc_mac.sv.
`timescale 1ns / 1ps

module tb;

    localparam int ClkPeriod     = 20;
    localparam int WarmupRounds  = 19;
    localparam int RandomItems   = 500;
    localparam int DrainCycles   = 200;
    localparam int TimeoutCycles = 400000;

    localparam logic [31:0] SeedStep = 32'd29943829;
    localparam logic [63:0] MulX0    = 64'd5115;
    localparam logic [63:0] MulX1    = 64'd1776;
    localparam logic [63:0] MulX2    = 64'd1492;
    localparam logic [63:0] MulX3    = 64'd2111111111;

    typedef enum logic {
        CMD_GENERATE = 1'b0,
        CMD_RESEED   = 1'b1
    } mwc_cmd_t;

    // Predicts the generator state and holds the words still owed by the block
    class mwc_scoreboard;
        logic [31:0] lag_words[4];
        logic [31:0] carry;
        logic [31:0] owed_words[$];
        int          errors;
        int          words_checked;
        int          reseeds;
        int          requests;

        function new();
            lag_words[0] = 32'h95d3474b;
            lag_words[1] = 32'h035cf1f7;
            lag_words[2] = 32'hfd43995f;
            lag_words[3] = 32'h5dfc55fb;
            carry        = 32'h334a9229;
            errors        = 0;
            words_checked = 0;
            reseeds       = 0;
            requests      = 0;
        endfunction

        // One multiply-with-carry round: low half becomes the newest lag word
        function logic [31:0] step_word();
            logic [63:0] sum;
            sum = {32'd0, lag_words[0]} * MulX0 + {32'd0, lag_words[1]} * MulX1
                + {32'd0, lag_words[2]} * MulX2 + {32'd0, lag_words[3]} * MulX3
                + {32'd0, carry};
            lag_words[3] = lag_words[2];
            lag_words[2] = lag_words[1];
            lag_words[1] = lag_words[0];
            lag_words[0] = sum[31:0];
            carry        = sum[63:32];
            return lag_words[0];
        endfunction

        // Refill all five words from the seed chain, then run the silent warm-up
        function void reseed_words(logic [31:0] seed);
            logic [31:0] s;
            logic [31:0] discard;
            s = seed;
            for (int k = 0; k < 4; k++) begin
                s = s * SeedStep - 32'd1;
                lag_words[k] = s;
            end
            s = s * SeedStep - 32'd1;
            carry = s;
            for (int k = 0; k < WarmupRounds; k++) begin
                discard = step_word();
            end
        endfunction

        function void note_request(mwc_cmd_t cmd, logic [31:0] seed);
            requests++;
            if (cmd == CMD_RESEED) begin
                reseeds++;
                reseed_words(seed);
            end else begin
                owed_words.push_back(step_word());
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_word(logic [31:0] word);
            logic [31:0] want;
            if (owed_words.size() == 0) begin
                report_mismatch($sformatf("word %08h arrived with none owed", word));
            end else begin
                want = owed_words.pop_front();
                words_checked++;
                if (word !== want) begin
                    report_mismatch($sformatf("random_word %08h, predicted %08h", word, want));
                end
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int send_idle_pct = 10;
    int recv_idle_pct = 88;

    mwc_scoreboard sb = new();

    multiply_with_carry_rng #(
        .WARMUP_ROUNDS(WarmupRounds)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [31:0] seed_value
        .s_tuser (s_tuser),   // [0] cmd
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // [31:0] random_word
    );

    always #(ClkPeriod / 2) aclk = ~aclk;

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watch both channels; values read here are the ones sampled at this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_word(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_request(mwc_cmd_t'(s_tuser), s_tdata);
            end
        end
    end

    // Present one request, with optional idle cycles first; return at its acceptance
    task send_request(input mwc_cmd_t cmd, input logic [31:0] seed);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= seed;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly word requests, with a reseed now and then
    task send_random_burst(input int count);
        mwc_cmd_t cmd;
        for (int i = 0; i < count; i++) begin
            cmd = ($urandom_range(0, 99) < 12) ? CMD_RESEED : CMD_GENERATE;
            send_request(cmd, $urandom);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Words straight from the reset state
        send_request(CMD_GENERATE, 32'h0000_0000);
        send_request(CMD_GENERATE, 32'hffff_ffff);
        send_request(CMD_GENERATE, 32'h0000_0000);
        // Seed extremes and bit patterns, each followed by a word
        send_request(CMD_RESEED,   32'h0000_0000);
        send_request(CMD_GENERATE, 32'h0000_0000);
        send_request(CMD_GENERATE, 32'h0000_0000);
        send_request(CMD_RESEED,   32'hffff_ffff);
        send_request(CMD_GENERATE, 32'h0000_0000);
        send_request(CMD_RESEED,   32'h0000_0001);
        send_request(CMD_GENERATE, 32'hffff_ffff);
        send_request(CMD_RESEED,   32'h8000_0000);
        send_request(CMD_GENERATE, 32'h0000_0000);
        send_request(CMD_RESEED,   32'haaaa_aaaa);
        send_request(CMD_GENERATE, 32'h5555_5555);
        send_request(CMD_RESEED,   32'h5555_5555);
        send_request(CMD_GENERATE, 32'haaaa_aaaa);
        // Same seed again must restart the same sequence
        send_request(CMD_RESEED,   32'h0000_0000);
        send_request(CMD_GENERATE, 32'h0000_0000);
        // Back-to-back reseeds: only the last one counts
        send_request(CMD_RESEED,   32'h1234_5678);
        send_request(CMD_RESEED,   32'h9abc_def0);
        send_request(CMD_GENERATE, 32'h0000_0000);
        send_request(CMD_GENERATE, 32'h0000_0000);

        // Busy sender against a heavily stalling receiver
        send_random_burst(RandomItems / 3);
        // Mostly idle sender, receiver rarely stalls
        send_idle_pct = 88;
        recv_idle_pct = 10;
        send_random_burst(RandomItems / 3);
        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_burst(RandomItems - 2 * (RandomItems / 3));
        s_tvalid <= 1'b0;

        // Drain owed words, then let any trailing warm-up finish
        while (sb.owed_words.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("Ran %0d requests (%0d reseeds) under three pacing modes; %0d words checked",
                 sb.requests, sb.reseeds, sb.words_checked);
        $display("Mismatches: %0d", sb.errors);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #(longint'(TimeoutCycles) * ClkPeriod);
        $display("Timeout after %0d cycles", TimeoutCycles);
        $display("Regression FAIL");
        $finish;
    end

endmodule
